// File: rtl/core/dsrr_pkg.sv
// shared types and constants for the decimated sample ring recorder
// no dependencies; imported by dsrr_ctrl, dsrr_datapath and the top level
`default_nettype none

package dsrr_pkg;

    localparam int DEFAULT_DEPTH = 512;

    localparam int MODE_W     = 2;
    localparam int TIME_W     = 32;
    localparam int POS_W      = 16;
    localparam int FLIGHT_W   = 24;
    localparam int INDEX_W    = 9;
    localparam int COUNT_W    = 10;
    localparam int INTERVAL_W = 16;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 16'd100;

    localparam logic [MODE_W-1:0] MODE_START  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STOP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd3;

    // commands from the controller to the datapath, all single-cycle
    typedef struct packed {
        logic accept;
        logic do_start;
        logic do_stop;
        logic do_sample;
        logic do_read;
    } t_cmd;

    // status from the datapath, valid in the cycle a word is offered
    typedef struct packed {
        logic recording;
        logic interval_ok;
        logic index_ok;
    } t_status;

endpackage

`default_nettype wire

// File: rtl/core/dsrr_ctrl.sv
// controller: accepts a word, decodes the mode and issues datapath commands
// depends on dsrr_pkg
`default_nettype none

module dsrr_ctrl (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [dsrr_pkg::MODE_W-1:0]  i_mode,
    input  wire dsrr_pkg::t_status            i_status,
    output dsrr_pkg::t_cmd                    o_cmd,
    output logic                              o_busy,
    output logic                              o_done
);
    import dsrr_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RESP = 1'b1;

    logic r_state;
    logic n_state;
    logic accept;

    assign accept = i_start && (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.accept    = accept;
        unique case (i_mode)
            MODE_START:  o_cmd.do_start = accept;
            MODE_STOP:   o_cmd.do_stop  = accept;
            // a sample is taken only while recording and once the interval has passed
            MODE_SAMPLE: o_cmd.do_sample = accept && i_status.recording
                                           && i_status.interval_ok;
            MODE_READ:   o_cmd.do_read  = accept && i_status.index_ok;
            default:     o_cmd = o_cmd;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_done = (r_state == ST_RESP);

endmodule

`default_nettype wire

// File: rtl/core/dsrr_datapath.sv
// datapath: record memories, ring pointer, fill count, timing registers
// depends on dsrr_pkg; driven by dsrr_ctrl commands
`default_nettype none

module dsrr_datapath #(
    parameter int DEPTH = dsrr_pkg::DEFAULT_DEPTH
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire dsrr_pkg::t_cmd                      i_cmd,
    output dsrr_pkg::t_status                        o_status,
    input  wire logic                                i_cfg_wr,
    input  wire logic [dsrr_pkg::INTERVAL_W-1:0]     i_cfg_data,
    input  wire logic [dsrr_pkg::TIME_W-1:0]         i_now_ms,
    input  wire logic                                i_has_positions,
    input  wire logic signed [dsrr_pkg::POS_W-1:0]   i_pos0,
    input  wire logic signed [dsrr_pkg::POS_W-1:0]   i_pos1,
    input  wire logic signed [dsrr_pkg::POS_W-1:0]   i_pos2,
    input  wire logic signed [dsrr_pkg::POS_W-1:0]   i_pos3,
    input  wire logic signed [dsrr_pkg::FLIGHT_W-1:0] i_flight_x,
    input  wire logic signed [dsrr_pkg::FLIGHT_W-1:0] i_flight_y,
    input  wire logic [dsrr_pkg::INDEX_W-1:0]        i_read_index,
    output logic                                     o_is_recording,
    output logic [dsrr_pkg::COUNT_W-1:0]             o_sample_count,
    output logic [dsrr_pkg::TIME_W-1:0]              o_started_at_ms,
    output logic                                     o_stored,
    output logic                                     o_read_valid,
    output logic [dsrr_pkg::TIME_W-1:0]              o_read_time_ms,
    output logic signed [dsrr_pkg::POS_W-1:0]        o_read_pos0,
    output logic signed [dsrr_pkg::POS_W-1:0]        o_read_pos1,
    output logic signed [dsrr_pkg::POS_W-1:0]        o_read_pos2,
    output logic signed [dsrr_pkg::POS_W-1:0]        o_read_pos3,
    output logic signed [dsrr_pkg::FLIGHT_W-1:0]     o_read_flight_x,
    output logic signed [dsrr_pkg::FLIGHT_W-1:0]     o_read_flight_y
);
    import dsrr_pkg::*;

    localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int SW  = ((CW > INDEX_W) ? CW : INDEX_W) + 1;
    localparam int PW  = 4 * POS_W;
    localparam int FW  = 2 * FLIGHT_W;

    logic [TIME_W-1:0] mem_time   [DEPTH];
    logic [PW-1:0]     mem_pos    [DEPTH];
    logic [FW-1:0]     mem_flight [DEPTH];

    logic [AW-1:0]         r_wp;
    logic [CW-1:0]         r_count;
    logic                  r_recording;
    logic [TIME_W-1:0]     r_start_time;
    logic [TIME_W-1:0]     r_last_time;
    logic [INTERVAL_W-1:0] r_interval;
    logic                  r_stored;
    logic                  r_rvalid;
    logic [TIME_W-1:0]     r_rd_time;
    logic [PW-1:0]         r_rd_pos;
    logic [FW-1:0]         r_rd_flight;

    logic [AW-1:0]     n_wp;
    logic [CW-1:0]     n_count;
    logic [TIME_W-1:0] elapsed;
    logic              full;
    logic [SW-1:0]     idx_ext;
    logic [SW-1:0]     addr_sum;
    logic [SW-1:0]     addr_wrap;
    logic [AW-1:0]     rd_addr;
    logic [PW-1:0]     wr_pos;
    logic [FW-1:0]     wr_flight;

    assign elapsed = i_now_ms - r_last_time;
    assign full    = (r_count == CW'(DEPTH));
    assign idx_ext = SW'(i_read_index);

    // oldest record sits at the write pointer once the ring has wrapped
    assign addr_sum  = (full ? SW'(r_wp) : '0) + idx_ext;
    assign addr_wrap = (addr_sum >= SW'(DEPTH)) ? (addr_sum - SW'(DEPTH)) : addr_sum;
    assign rd_addr   = addr_wrap[AW-1:0];

    assign n_wp    = (r_wp == AW'(DEPTH - 1)) ? '0 : (r_wp + 1'b1);
    assign n_count = full ? r_count : (r_count + 1'b1);

    assign wr_pos    = i_has_positions ? {i_pos3, i_pos2, i_pos1, i_pos0} : '0;
    assign wr_flight = {i_flight_y, i_flight_x};

    assign o_status.recording   = r_recording;
    assign o_status.interval_ok = (elapsed >= TIME_W'(r_interval));
    assign o_status.index_ok    = (idx_ext < SW'(r_count));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp         <= '0;
            r_count      <= '0;
            r_recording  <= 1'b0;
            r_start_time <= '0;
            r_last_time  <= '0;
            r_interval   <= INTERVAL_RST;
            r_stored     <= 1'b0;
            r_rvalid     <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                r_interval <= i_cfg_data;
            end
            if (i_cmd.accept) begin
                r_stored <= i_cmd.do_sample;
                r_rvalid <= i_cmd.do_read;
            end
            if (i_cmd.do_start) begin
                r_wp         <= '0;
                r_count      <= '0;
                r_start_time <= i_now_ms;
                r_last_time  <= '0;
                r_recording  <= 1'b1;
            end
            if (i_cmd.do_stop) begin
                r_recording <= 1'b0;
            end
            if (i_cmd.do_sample) begin
                r_last_time <= i_now_ms;
                r_wp        <= n_wp;
                r_count     <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_sample) begin
            mem_time[r_wp]   <= i_now_ms - r_start_time;
            mem_pos[r_wp]    <= wr_pos;
            mem_flight[r_wp] <= wr_flight;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_read) begin
            r_rd_time   <= mem_time[rd_addr];
            r_rd_pos    <= mem_pos[rd_addr];
            r_rd_flight <= mem_flight[rd_addr];
        end
    end

    assign o_is_recording  = r_recording;
    assign o_sample_count  = COUNT_W'(r_count);
    assign o_started_at_ms = r_recording ? r_start_time : '0;
    assign o_stored        = r_stored;
    assign o_read_valid    = r_rvalid;

    // read fields read as zero unless the index hit a stored record
    assign o_read_time_ms  = r_rvalid ? r_rd_time : '0;
    assign o_read_pos0     = r_rvalid ? $signed(r_rd_pos[POS_W-1:0]) : '0;
    assign o_read_pos1     = r_rvalid ? $signed(r_rd_pos[2*POS_W-1:POS_W]) : '0;
    assign o_read_pos2     = r_rvalid ? $signed(r_rd_pos[3*POS_W-1:2*POS_W]) : '0;
    assign o_read_pos3     = r_rvalid ? $signed(r_rd_pos[4*POS_W-1:3*POS_W]) : '0;
    assign o_read_flight_x = r_rvalid ? $signed(r_rd_flight[FLIGHT_W-1:0]) : '0;
    assign o_read_flight_y = r_rvalid ? $signed(r_rd_flight[2*FLIGHT_W-1:FLIGHT_W]) : '0;

endmodule

`default_nettype wire

// File: rtl/core/decimated_sample_ring_recorder_unit.sv
// top level of the decimated sample ring recorder
// depends on dsrr_pkg, dsrr_ctrl and dsrr_datapath
//
//   channel   handshake                  payload
//   command   i_start / o_busy           i_mode, i_now_ms, i_has_positions, i_pos0..3,
//                                        i_flight_x, i_flight_y, i_read_index
//   result    o_done (one-cycle strobe)  o_is_recording .. o_read_flight_y
//   config    i_cfg_valid / o_cfg_ready  i_cfg_data (sample interval in ms)
//
// a word is taken when i_start is high and o_busy low; its result shows in the next cycle
// for exactly one cycle under o_done, as the result and the memory read are registered;
// o_busy is high during the result cycle
// synchronous active-low reset clears pointer, count, flags and sets the interval to 100
// the result side cannot stall; o_cfg_ready is always high
`default_nettype none

module decimated_sample_ring_recorder_unit #(
    parameter int DEPTH = dsrr_pkg::DEFAULT_DEPTH
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_start,
    output logic                                      o_busy,
    input  wire logic [dsrr_pkg::MODE_W-1:0]          i_mode,
    input  wire logic [dsrr_pkg::TIME_W-1:0]          i_now_ms,
    input  wire logic                                 i_has_positions,
    input  wire logic signed [dsrr_pkg::POS_W-1:0]    i_pos0,
    input  wire logic signed [dsrr_pkg::POS_W-1:0]    i_pos1,
    input  wire logic signed [dsrr_pkg::POS_W-1:0]    i_pos2,
    input  wire logic signed [dsrr_pkg::POS_W-1:0]    i_pos3,
    input  wire logic signed [dsrr_pkg::FLIGHT_W-1:0] i_flight_x,
    input  wire logic signed [dsrr_pkg::FLIGHT_W-1:0] i_flight_y,
    input  wire logic [dsrr_pkg::INDEX_W-1:0]         i_read_index,
    output logic                                      o_done,
    output logic                                      o_is_recording,
    output logic [dsrr_pkg::COUNT_W-1:0]              o_sample_count,
    output logic [dsrr_pkg::TIME_W-1:0]               o_started_at_ms,
    output logic                                      o_stored,
    output logic                                      o_read_valid,
    output logic [dsrr_pkg::TIME_W-1:0]               o_read_time_ms,
    output logic signed [dsrr_pkg::POS_W-1:0]         o_read_pos0,
    output logic signed [dsrr_pkg::POS_W-1:0]         o_read_pos1,
    output logic signed [dsrr_pkg::POS_W-1:0]         o_read_pos2,
    output logic signed [dsrr_pkg::POS_W-1:0]         o_read_pos3,
    output logic signed [dsrr_pkg::FLIGHT_W-1:0]      o_read_flight_x,
    output logic signed [dsrr_pkg::FLIGHT_W-1:0]      o_read_flight_y,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [dsrr_pkg::INTERVAL_W-1:0]      i_cfg_data
);
    import dsrr_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    dsrr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_mode   (i_mode),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (o_busy),
        .o_done   (o_done)
    );

    dsrr_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg_wr        (i_cfg_valid && o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_now_ms        (i_now_ms),
        .i_has_positions (i_has_positions),
        .i_pos0          (i_pos0),
        .i_pos1          (i_pos1),
        .i_pos2          (i_pos2),
        .i_pos3          (i_pos3),
        .i_flight_x      (i_flight_x),
        .i_flight_y      (i_flight_y),
        .i_read_index    (i_read_index),
        .o_is_recording  (o_is_recording),
        .o_sample_count  (o_sample_count),
        .o_started_at_ms (o_started_at_ms),
        .o_stored        (o_stored),
        .o_read_valid    (o_read_valid),
        .o_read_time_ms  (o_read_time_ms),
        .o_read_pos0     (o_read_pos0),
        .o_read_pos1     (o_read_pos1),
        .o_read_pos2     (o_read_pos2),
        .o_read_pos3     (o_read_pos3),
        .o_read_flight_x (o_read_flight_x),
        .o_read_flight_y (o_read_flight_y)
    );

endmodule

`default_nettype wire
